### rtl/maximal_points_2d_top_defines.svh
// Assertion macros shared by the maximal points checker.
`ifndef MAXIMAL_POINTS_2D_TOP_DEFINES_SVH
`define MAXIMAL_POINTS_2D_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MP2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MP2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mp2d_pkg.sv
// Shared constants, state type and controller interface structs for the maximal points block.
package mp2d_pkg;

    localparam int MAX_POINTS = 64;
    localparam int AW         = $clog2(MAX_POINTS);
    localparam int CW         = $clog2(MAX_POINTS + 1);
    localparam int DW         = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDI,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic init_pt;
        logic scan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic scan_end;
        logic pt_last;
        logic out_free;
    } t_status;

endpackage

### rtl/mp2d_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mp2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mp2d_ctrl.sv
// Sequencer that steps through loading, the pairwise scan and the emission of results.
module mp2d_ctrl import mp2d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.in_valid && i_status.in_last) begin
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.pt_last ? S_IDLE : S_RDI;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.in_ready = (r_state == S_IDLE);
        o_cmd.init_pt  = (r_state == S_RDI);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.emit     = (r_state == S_EMIT) && i_status.out_free;
    end

endmodule

### rtl/mp2d_dp.sv
// Point stores, scan counters, dominance compare and the result register.
module mp2d_dp import mp2d_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic signed [DW-1:0] i_in_x,
    input  logic signed [DW-1:0] i_in_y,
    input  logic                 i_last_point,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [DW-1:0] o_out_x,
    output logic signed [DW-1:0] o_out_y,
    output logic                 o_is_maximal,
    output logic                 o_overflow,
    output logic                 o_last_result
);

    logic [CW-1:0]         r_count;
    logic                  r_ovf_seen;
    logic [CW-1:0]         r_n;
    logic                  r_ovf;
    logic [AW-1:0]         r_i;
    logic [AW-1:0]         r_j;
    logic                  r_cmp_v;
    logic [AW-1:0]         r_cmp_j;
    logic                  r_max;
    logic                  r_out_valid;
    logic signed [DW-1:0]  r_out_x;
    logic signed [DW-1:0]  r_out_y;
    logic                  r_out_max;
    logic                  r_out_ovf;
    logic                  r_out_last;

    logic                  accept;
    logic                  has_room;
    logic                  we;
    logic [CW-1:0]         count_after;
    logic [2*DW-1:0]       data_a;
    logic [2*DW-1:0]       data_b;
    logic signed [DW-1:0]  px;
    logic signed [DW-1:0]  py;
    logic signed [DW-1:0]  qx;
    logic signed [DW-1:0]  qy;
    logic                  dom;
    logic                  out_free;
    logic                  pt_last;

    assign accept      = i_cmd.in_ready && i_in_valid;
    assign has_room    = (r_count < CW'(MAX_POINTS));
    assign we          = accept && has_room;
    assign count_after = has_room ? r_count + CW'(1) : r_count;

    mp2d_ram #(.WIDTH(2 * DW), .DEPTH(MAX_POINTS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_x, i_in_y}),
        .i_raddr (r_i),
        .o_rdata (data_a)
    );

    mp2d_ram #(.WIDTH(2 * DW), .DEPTH(MAX_POINTS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_x, i_in_y}),
        .i_raddr (r_j),
        .o_rdata (data_b)
    );

    assign px  = $signed(data_a[2*DW-1:DW]);
    assign py  = $signed(data_a[DW-1:0]);
    assign qx  = $signed(data_b[2*DW-1:DW]);
    assign qy  = $signed(data_b[DW-1:0]);
    assign dom = (qx >= px) && (qy >= py) && ((qx > px) || (qy > py));

    assign out_free = !r_out_valid || i_out_ready;
    assign pt_last  = (CW'(r_i) == r_n - CW'(1));

    always_comb begin
        o_status.in_valid = i_in_valid;
        o_status.in_last  = i_last_point;
        o_status.scan_end = (CW'(r_j) == r_n - CW'(1));
        o_status.pt_last  = pt_last;
        o_status.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
            r_cmp_v    <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.scan;
            if (accept) begin
                if (i_last_point) begin
                    r_count    <= '0;
                    r_ovf_seen <= 1'b0;
                end else begin
                    r_count    <= count_after;
                    r_ovf_seen <= r_ovf_seen || !has_room;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_point) begin
            r_n   <= count_after;
            r_ovf <= r_ovf_seen || !has_room;
            r_i   <= '0;
        end else if (i_cmd.emit && !pt_last) begin
            r_i <= r_i + AW'(1);
        end
        if (i_cmd.init_pt) begin
            r_j   <= '0;
            r_max <= 1'b1;
        end else begin
            if (i_cmd.scan) begin
                r_j <= r_j + AW'(1);
            end
            if (r_cmp_v && dom && (r_cmp_j != r_i)) begin
                r_max <= 1'b0;
            end
        end
        r_cmp_j <= r_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x    <= px;
            r_out_y    <= py;
            r_out_max  <= r_max;
            r_out_ovf  <= r_ovf;
            r_out_last <= pt_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_is_maximal  = r_out_max;
    assign o_overflow    = r_out_ovf;
    assign o_last_result = r_out_last;

endmodule

### rtl/maximal_points_2d_top.sv
// Top level of the 2D maximal points block.
// Points are loaded one per cycle into a 64-entry store while o_in_ready is high; a
// point that arrives with the store full is dropped and flags overflow for the set.
// The request marked last_point starts the evaluation: for each of the n stored points
// the block reads the point, compares it against all n stored points through one
// comparator fed by the second read port, and then emits one result once the output
// register is free, with o_in_ready low throughout. Results leave in load order, and
// the final result of the set may still wait in the output register while loading of
// the next set has begun.
module maximal_points_2d_top import mp2d_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [DW-1:0] i_in_x,
    input  logic signed [DW-1:0] i_in_y,
    input  logic                 i_last_point,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [DW-1:0] o_out_x,
    output logic signed [DW-1:0] o_out_y,
    output logic                 o_is_maximal,
    output logic                 o_overflow,
    output logic                 o_last_result
);

    t_cmd    cmd;
    t_status status;

    mp2d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mp2d_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_x        (i_in_x),
        .i_in_y        (i_in_y),
        .i_last_point  (i_last_point),
        .i_in_valid    (i_in_valid),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_is_maximal  (o_is_maximal),
        .o_overflow    (o_overflow),
        .o_last_result (o_last_result)
    );

    assign o_in_ready = cmd.in_ready;

endmodule

### rtl/mp2d_chk.sv
// Port-level checker for the maximal points block and its bind to the top level.
`include "maximal_points_2d_top_defines.svh"

module mp2d_chk import mp2d_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_last_point,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic signed [DW-1:0] o_out_x,
    input logic signed [DW-1:0] o_out_y,
    input logic                 o_is_maximal,
    input logic                 o_overflow,
    input logic                 o_last_result
);

    `MP2D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        i_rst_n && o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_is_maximal)
            && $stable(o_overflow) && $stable(o_last_result),
        "result changed while stalled")
    `MP2D_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n,
        i_rst_n && i_in_valid && o_in_ready && i_last_point,
        !o_in_ready,
        "input still open after the last point of a set")
    `MP2D_ASSERT_NEXT(a_load_open, i_clk, i_rst_n,
        i_rst_n && i_in_valid && o_in_ready && !i_last_point,
        o_in_ready,
        "input closed after a point that was not last")
    `MP2D_ASSERT_NOW(a_idle_result, i_clk, i_rst_n,
        o_in_ready && o_out_valid,
        o_last_result,
        "result other than the final one pending while loading")

endmodule

bind maximal_points_2d_top mp2d_chk u_chk (.*);
